// ===== hw/rtl/brfifo_pkg.sv =====
// Package for the byte ring FIFO with unput.
// Holds the command and status codes and the fixed field widths.
// No dependencies.
package brfifo_pkg;

	// Fixed field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CAP_W   = 9;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned IN_W    = 8;
	localparam int unsigned OUT_W   = 32;
	localparam int unsigned OUT_USED_W = STAT_W + BYTE_W + 2 * CAP_W;

	// Command carried by each input beat
	typedef enum logic [KIND_W-1:0] {
		KIND_PUT   = 2'd0,
		KIND_GET   = 2'd1,
		KIND_DEL   = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	// Status returned with each result beat
	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// ===== hw/rtl/byte_ring_fifo_with_unput.sv =====
// Byte ring FIFO with put, get, delete-last and clear commands; uses brfifo_pkg and brfifo_ram.
// A result beat is registered and appears in the cycle after its command beat is accepted.
// Throughput: one command per cycle; s_tready drops only while a result beat waits on m_tready.
// Reset: pointers and count go to zero, capacity to min(256, DEPTH); the byte store is not
// cleared and needs no clearing pass, since an entry is read only after it was written.
module byte_ring_fifo_with_unput #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Capacity register write
	input  logic                             buffer_size_we,
	input  logic [brfifo_pkg::CAP_W-1:0]     buffer_size,
	// Command stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [brfifo_pkg::IN_W-1:0]      s_tdata,  // [7:0] data_in
	input  logic [brfifo_pkg::KIND_W-1:0]    s_tuser,  // [1:0] kind
	// Result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [1:0] status, [9:2] data_out, [18:10] fill_level, [27:19] free_space, [31:28] zero
	output logic [brfifo_pkg::OUT_W-1:0]     m_tdata
);

	import brfifo_pkg::*;

	localparam int unsigned PTR_W   = $clog2(DEPTH);
	localparam int unsigned CMP_W   = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
	localparam int unsigned CAP_RST = (DEPTH < 256) ? DEPTH : 256;

	// Architectural state
	logic [CAP_W-1:0] cap_q;
	logic [PTR_W-1:0] rp_q, wp_q;
	logic [CAP_W-1:0] cnt_q;

	// Result register
	logic             m_valid_s1;
	status_t          status_s1;
	logic             get_ok_s1;
	logic [CAP_W-1:0] fill_s1;
	logic [CAP_W-1:0] free_s1;

	// Next-state values
	logic [PTR_W-1:0] rp_d, wp_d, wp_inc, rp_inc, wp_dec;
	logic [CAP_W-1:0] cnt_d;
	status_t          status_d;
	logic             ram_we, get_ok;
	logic             accept;
	logic [CAP_W-1:0] cap_wr;
	logic [BYTE_W-1:0] ram_rdata;
	kind_t            kind;

	assign kind     = kind_t'(s_tuser);
	assign s_tready = !m_valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Clamp the written capacity into 1..DEPTH.
	always_comb begin
		if (buffer_size == '0) begin
			cap_wr = CAP_W'(1);
		end else if (32'(buffer_size) > DEPTH) begin
			cap_wr = CAP_W'(DEPTH);
		end else begin
			cap_wr = buffer_size;
		end
	end

	// Pointer steps with wrap at the capacity in use
	assign wp_inc = (CMP_W'(wp_q) + CMP_W'(1) == CMP_W'(cap_q)) ? '0 : wp_q + PTR_W'(1);
	assign rp_inc = (CMP_W'(rp_q) + CMP_W'(1) == CMP_W'(cap_q)) ? '0 : rp_q + PTR_W'(1);
	assign wp_dec = (wp_q == '0) ? PTR_W'(cap_q - CAP_W'(1)) : wp_q - PTR_W'(1);

	// Command decode and next state
	always_comb begin
		rp_d     = rp_q;
		wp_d     = wp_q;
		cnt_d    = cnt_q;
		status_d = ST_DONE;
		ram_we   = 1'b0;
		get_ok   = 1'b0;
		unique case (kind)
			KIND_PUT: begin
				if (cnt_q >= cap_q) begin
					status_d = ST_FULL;
				end else begin
					ram_we = 1'b1;
					wp_d   = wp_inc;
					cnt_d  = cnt_q + CAP_W'(1);
				end
			end
			KIND_GET: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					get_ok = 1'b1;
					rp_d   = rp_inc;
					cnt_d  = cnt_q - CAP_W'(1);
				end
			end
			KIND_DEL: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					wp_d  = wp_dec;
					cnt_d = cnt_q - CAP_W'(1);
				end
			end
			KIND_CLEAR: begin
				rp_d  = '0;
				wp_d  = '0;
				cnt_d = '0;
			end
		endcase
	end

	// State registers; a capacity write also empties the FIFO.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RST);
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else if (buffer_size_we) begin
			cap_q <= cap_wr;
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			rp_q  <= rp_d;
			wp_q  <= wp_d;
			cnt_q <= cnt_d;
		end
	end

	// Byte store; the read beat lands together with the result register.
	brfifo_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && ram_we),
		.waddr(wp_q),
		.wdata(s_tdata[BYTE_W-1:0]),
		.re   (accept),
		.raddr(rp_q),
		.rdata(ram_rdata)
	);

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			m_valid_s1 <= s_tvalid;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			get_ok_s1 <= get_ok;
			fill_s1   <= cnt_d;
			free_s1   <= cap_q - cnt_d;
		end
	end

	// Pack the result beat; data_out is zero unless a get succeeded.
	assign m_tvalid = m_valid_s1;
	assign m_tdata  = {(OUT_W - OUT_USED_W)'(0), free_s1, fill_s1,
		(get_ok_s1 ? ram_rdata : BYTE_W'(0)), status_s1};

	// Checks on the internal bookkeeping
	logic [CMP_W-1:0] rp_plus_cnt, wp_expect;
	assign rp_plus_cnt = CMP_W'(rp_q) + CMP_W'(cnt_q);
	assign wp_expect   = (rp_plus_cnt >= CMP_W'(cap_q)) ? rp_plus_cnt - CMP_W'(cap_q)
		: rp_plus_cnt;

	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_q)
		else $error("stored count exceeds capacity");

	a_ptr_relation: assert property (@(posedge clk) disable iff (!arst_n)
		wp_expect == CMP_W'(wp_q))
		else $error("write pointer does not match read pointer plus count");

	a_fill_free_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_s1 |-> (CMP_W'(fill_s1) + CMP_W'(free_s1) == CMP_W'(cap_q)))
		else $error("fill level and free space do not add up to capacity");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_s1 && !m_tready) |=> ($stable(cnt_q) && $stable(rp_q)) || $past(buffer_size_we))
		else $error("state moved while the result beat was stalled");

	a_get_data_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_s1 && status_s1 != ST_DONE) |-> !get_ok_s1)
		else $error("rejected command marked as a successful get");

endmodule

// ===== hw/rtl/brfifo_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the FIFO byte store. No package dependencies.
module brfifo_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
